// ===== rtl/lbts_pkg.sv =====
// ----------------------------------------------------------------------------
// lbts_pkg: shared types and constants of the target select block
// Item kinds, strategy codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lbts_pkg;

   localparam int KIND_BITS = 3;
   localparam int SLOT_BITS = 4;
   localparam int WEIGHT_BITS = 8;
   localparam int LOAD_IN_BITS = 16;
   localparam int RAND_BITS = 32;
   localparam int CNT_BITS = 32;

   localparam logic [KIND_BITS-1:0] KIND_ADD = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_REMOVE = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_HEALTH = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_LOAD = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_CLEAR = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_SELECT = 3'd5;

   localparam logic [1:0] STRAT_RR = 2'd0;
   localparam logic [1:0] STRAT_LEAST = 2'd1;
   localparam logic [1:0] STRAT_RANDOM = 2'd2;
   localparam logic [1:0] STRAT_WEIGHTED = 2'd3;

   typedef struct packed {
      logic apply_event;
      logic start_scan;
      logic start_div;
      logic start_pick;
      logic emit;
   } lbts_cmd_type;

   typedef struct packed {
      logic is_select;
      logic scan_done;
      logic div_done;
      logic pick_done;
   } lbts_status_type;

endpackage

// ===== rtl/lbts_divider.sv =====
// ----------------------------------------------------------------------------
// lbts_divider: restoring remainder unit
// Computes a 32-bit dividend modulo a 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module lbts_divider
   import lbts_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [RAND_BITS-1:0] dividend,
   input  logic [RAND_BITS-1:0] divisor,
   output logic                done,
   output logic [RAND_BITS-1:0] remainder
);

   logic [RAND_BITS-1:0] quot_ff, quot_in;
   logic [RAND_BITS-1:0] rem_ff, rem_in;
   logic [5:0]           count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic [RAND_BITS:0]   shifted;
   logic [RAND_BITS:0]   trial;

   always_comb begin
      shifted = {rem_ff, quot_ff[RAND_BITS-1]};
      trial = shifted - {1'b0, divisor};
      quot_in = quot_ff;
      rem_in = rem_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      done = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in = '0;
         count_in = 6'(RAND_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[RAND_BITS-2:0], 1'b0};
         rem_in = trial[RAND_BITS] ? shifted[RAND_BITS-1:0] : trial[RAND_BITS-1:0];
         count_in = count_ff - 6'd1;
         if (count_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end else begin
         done = 1'b0;
      end
      if (busy_ff && count_ff == 6'd1) begin
         done = 1'b1;
      end
   end

   assign remainder = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
   end

endmodule

// ===== rtl/lbts_datapath.sv =====
// ----------------------------------------------------------------------------
// lbts_datapath: slot table and selection datapath
// Holds the slot table, counts eligible slots and totals, runs the remainder
// unit and walks the slots one per cycle to find the chosen target.
// ----------------------------------------------------------------------------
module lbts_datapath
   import lbts_pkg::*;
#(
   parameter int NUM_TARGETS = 16,
   parameter int LOAD_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lbts_cmd_type            cmd,
   output lbts_status_type         status,
   input  logic [1:0]              strategy,
   input  logic [KIND_BITS-1:0]    kind,
   input  logic [SLOT_BITS-1:0]    target_slot,
   input  logic [WEIGHT_BITS-1:0]  weight,
   input  logic                    healthy,
   input  logic [LOAD_IN_BITS-1:0] load_value,
   input  logic [RAND_BITS-1:0]    random_value,
   output logic                    found,
   output logic [SLOT_BITS-1:0]    chosen_slot
);

   localparam int IDX_BITS = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
   localparam int CNT_W = $clog2(NUM_TARGETS + 1);
   localparam int SUM_W = WEIGHT_BITS + CNT_W;

   logic [NUM_TARGETS-1:0] present_ff, healthy_ff, known_ff;
   logic [WEIGHT_BITS-1:0] weight_ff [NUM_TARGETS];
   logic [LOAD_BITS-1:0]   load_ff [NUM_TARGETS];
   logic [CNT_BITS-1:0]    rot_ff, rot_in;

   logic [NUM_TARGETS-1:0] elig;
   logic [IDX_BITS:0]      idx_ff, idx_in;
   logic                   scanning_ff, scanning_in;
   logic                   walking_ff, walking_in;
   logic [CNT_W-1:0]       n_ff, n_in;
   logic [SUM_W-1:0]       total_ff, total_in;
   logic [IDX_BITS-1:0]    last_ff, last_in;
   logic                   mode_rr_ff, mode_rr_in;
   logic [RAND_BITS-1:0]   rnd_ff, rnd_in;
   logic [RAND_BITS-1:0]   target_ff, target_in;
   logic [SUM_W-1:0]       acc_ff, acc_in;
   logic [CNT_W-1:0]       seen_ff, seen_in;
   logic                   have_ff, have_in;
   logic [LOAD_BITS-1:0]   best_ff, best_in;
   logic [IDX_BITS-1:0]    pick_ff, pick_in;
   logic                   picked_ff, picked_in;
   logic                   found_ff, found_in;
   logic [SLOT_BITS-1:0]   chosen_ff, chosen_in;
   logic [IDX_BITS-1:0]    cur;
   logic                   in_range;
   logic                   div_done;
   logic [RAND_BITS-1:0]   div_rem;
   logic [RAND_BITS-1:0]   div_dividend, div_divisor;
   logic [LOAD_BITS-1:0]   cur_load;
   logic [SUM_W-1:0]       acc_next;

   assign elig = present_ff & healthy_ff;
   assign cur = idx_ff[IDX_BITS-1:0];
   assign in_range = ({{(32-SLOT_BITS){1'b0}}, target_slot} < 32'(NUM_TARGETS));

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         healthy_ff <= '0;
         known_ff <= '0;
         for (int i = 0; i < NUM_TARGETS; i++) begin
            weight_ff[i] <= '0;
            load_ff[i] <= '0;
         end
      end else if (cmd.apply_event) begin
         case (kind)
            KIND_ADD: begin
               if (in_range) begin
                  present_ff[IDX_BITS'(target_slot)] <= 1'b1;
                  healthy_ff[IDX_BITS'(target_slot)] <= 1'b1;
                  weight_ff[IDX_BITS'(target_slot)] <= weight;
               end
            end
            KIND_REMOVE: begin
               if (in_range) begin
                  present_ff[IDX_BITS'(target_slot)] <= 1'b0;
                  healthy_ff[IDX_BITS'(target_slot)] <= 1'b0;
               end
            end
            KIND_HEALTH: begin
               if (in_range) begin
                  healthy_ff[IDX_BITS'(target_slot)] <= healthy;
               end
            end
            KIND_LOAD: begin
               if (in_range) begin
                  load_ff[IDX_BITS'(target_slot)] <=
                     LOAD_BITS'({{(32-LOAD_IN_BITS){1'b0}}, load_value});
                  known_ff[IDX_BITS'(target_slot)] <= 1'b1;
               end
            end
            KIND_CLEAR: begin
               known_ff <= '0;
               for (int i = 0; i < NUM_TARGETS; i++) begin
                  load_ff[i] <= '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      div_dividend = (strategy == STRAT_RANDOM || strategy == STRAT_WEIGHTED)
                     ? rnd_ff : rot_ff;
      div_divisor = (strategy == STRAT_WEIGHTED) ? RAND_BITS'(total_ff)
                                                 : RAND_BITS'(n_ff);
   end

   lbts_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.start_div),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      cur_load = known_ff[cur] ? load_ff[cur] : '0;
      acc_next = acc_ff + SUM_W'(weight_ff[cur]);
      idx_in = idx_ff;
      scanning_in = scanning_ff;
      walking_in = walking_ff;
      n_in = n_ff;
      total_in = total_ff;
      last_in = last_ff;
      mode_rr_in = mode_rr_ff;
      rnd_in = rnd_ff;
      target_in = target_ff;
      acc_in = acc_ff;
      seen_in = seen_ff;
      have_in = have_ff;
      best_in = best_ff;
      pick_in = pick_ff;
      picked_in = picked_ff;
      found_in = found_ff;
      chosen_in = chosen_ff;
      rot_in = rot_ff;
      status.scan_done = 1'b0;
      status.pick_done = 1'b0;
      status.div_done = div_done;
      status.is_select = (kind == KIND_SELECT);
      if (cmd.start_scan) begin
         idx_in = '0;
         scanning_in = 1'b1;
         n_in = '0;
         total_in = '0;
         last_in = '0;
         rnd_in = random_value;
         mode_rr_in = (strategy == STRAT_RR) ||
                      (strategy == STRAT_LEAST && known_ff == '0);
      end else if (scanning_ff) begin
         if (elig[cur]) begin
            n_in = n_ff + CNT_W'(1);
            total_in = total_ff + SUM_W'(weight_ff[cur]);
            last_in = cur;
         end
         idx_in = idx_ff + (IDX_BITS+1)'(1);
         if (idx_ff == (IDX_BITS+1)'(NUM_TARGETS - 1)) begin
            scanning_in = 1'b0;
            status.scan_done = 1'b1;
         end
      end
      if (cmd.start_pick) begin
         idx_in = '0;
         walking_in = 1'b1;
         acc_in = '0;
         seen_in = '0;
         have_in = 1'b0;
         best_in = '0;
         picked_in = 1'b0;
         pick_in = last_ff;
         target_in = div_rem;
         found_in = (n_ff != '0);
         if (n_ff != '0 && mode_rr_ff) begin
            rot_in = rot_ff + CNT_BITS'(1);
         end
      end else if (walking_ff) begin
         if (elig[cur] && !picked_ff) begin
            seen_in = seen_ff + CNT_W'(1);
            acc_in = acc_next;
            if (mode_rr_ff || strategy == STRAT_RANDOM) begin
               if (RAND_BITS'(seen_ff) == target_ff) begin
                  pick_in = cur;
                  picked_in = 1'b1;
               end
            end else if (strategy == STRAT_LEAST) begin
               if (!have_ff || cur_load < best_ff) begin
                  have_in = 1'b1;
                  best_in = cur_load;
                  pick_in = cur;
               end
            end else if (total_ff != '0 && target_ff < RAND_BITS'(acc_next)) begin
               pick_in = cur;
               picked_in = 1'b1;
            end
         end
         idx_in = idx_ff + (IDX_BITS+1)'(1);
         if (idx_ff == (IDX_BITS+1)'(NUM_TARGETS - 1)) begin
            walking_in = 1'b0;
            status.pick_done = 1'b1;
         end
      end
      if (cmd.emit) begin
         chosen_in = found_ff ? SLOT_BITS'(pick_in) : '0;
      end
   end

   assign found = found_ff;
   assign chosen_slot = chosen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scanning_ff <= 1'b0;
         walking_ff <= 1'b0;
         rot_ff <= '0;
         found_ff <= 1'b0;
         chosen_ff <= '0;
      end else begin
         scanning_ff <= scanning_in;
         walking_ff <= walking_in;
         rot_ff <= rot_in;
         found_ff <= found_in;
         chosen_ff <= chosen_in;
      end
      idx_ff <= idx_in;
      n_ff <= n_in;
      total_ff <= total_in;
      last_ff <= last_in;
      mode_rr_ff <= mode_rr_in;
      rnd_ff <= rnd_in;
      target_ff <= target_in;
      acc_ff <= acc_in;
      seen_ff <= seen_in;
      have_ff <= have_in;
      best_ff <= best_in;
      pick_ff <= pick_in;
      picked_ff <= picked_in;
   end

endmodule

// ===== rtl/lbts_control.sv =====
// ----------------------------------------------------------------------------
// lbts_control: sequencer of the target select block
// Accepts beats, applies events and steps a select through scan, remainder
// and pick phases, then holds the result until the response beat is taken.
// ----------------------------------------------------------------------------
module lbts_control
   import lbts_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  lbts_status_type status,
   output lbts_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_DIV  = 6'b000100,
      ST_PICK = 6'b001000,
      ST_EMIT = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (status.is_select) begin
                  cmd.start_scan = 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  cmd.apply_event = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               cmd.start_div = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            cmd.start_pick = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.pick_done) begin
               cmd.emit = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/load_balancer_target_select_core.sv =====
// ----------------------------------------------------------------------------
// load_balancer_target_select_core: target select block, top level
// Event beats can follow back to back. A select beat scans NUM_TARGETS
// slots, runs the bit-serial remainder unit, starts the pick and walks the
// slots to find the target, then its response beat goes valid. One item
// is in flight at a time; the next request is taken from the cycle after
// the response beat. Synchronous active-high reset empties the slot table
// and clears the rotation counter and the strategy register.
// ----------------------------------------------------------------------------
module load_balancer_target_select_core
   import lbts_pkg::*;
#(
   parameter int NUM_TARGETS = 16,
   parameter int LOAD_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [KIND_BITS-1:0]    req_kind,
   input  logic [SLOT_BITS-1:0]    req_target_slot,
   input  logic [WEIGHT_BITS-1:0]  req_weight,
   input  logic                    req_healthy,
   input  logic [LOAD_IN_BITS-1:0] req_load_value,
   input  logic [RAND_BITS-1:0]    req_random_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_found,
   output logic [SLOT_BITS-1:0]    rsp_chosen_slot,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [1:0]              csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   lbts_cmd_type    cmd;
   lbts_status_type status;
   logic [1:0]      strategy_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? {30'd0, strategy_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff <= STRAT_RR;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0) begin
         strategy_ff <= csr_pwdata[1:0];
      end
   end

   lbts_control u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lbts_datapath #(
      .NUM_TARGETS (NUM_TARGETS),
      .LOAD_BITS   (LOAD_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .strategy     (strategy_ff),
      .kind         (req_kind),
      .target_slot  (req_target_slot),
      .weight       (req_weight),
      .healthy      (req_healthy),
      .load_value   (req_load_value),
      .random_value (req_random_value),
      .found        (rsp_found),
      .chosen_slot  (rsp_chosen_slot)
   );

endmodule

// ===== rtl/lbts_checker.sv =====
// ----------------------------------------------------------------------------
// lbts_checker: port-level checks of the target select block
// Watches the request, response and register ports of the top level.
// ----------------------------------------------------------------------------
module lbts_checker
   import lbts_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_found,
   input logic [SLOT_BITS-1:0] rsp_chosen_slot,
   input logic                 csr_pready
);

   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response beat is pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_chosen_slot)
      && $stable(rsp_found))
      else $error("response beat changed before it was taken");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_chosen_slot == '0)
      else $error("empty response carries a slot");

   a_ready_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid && req_ready)
      else $error("block not idle after the response beat");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("register port stalled");

endmodule

bind load_balancer_target_select_core lbts_checker u_chk (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_found       (rsp_found),
   .rsp_chosen_slot (rsp_chosen_slot),
   .csr_pready      (csr_pready)
);
